>>> sv/tst_pkg.sv
package tst_pkg;

  // Field widths of the external items.
  localparam int COORD_W   = 16;
  localparam int IDX_W     = 16;
  localparam int LVL_W     = 3;
  localparam int FRAC_BITS = 14;

  // Internal arithmetic widths, sized for a level of at most six.
  localparam int V_W   = 19;           // signed weighted corner sum
  localparam int MAG_W = 18;           // magnitude of that sum
  localparam int SQ_W  = 2 * MAG_W;    // square of one component
  localparam int S_W   = SQ_W + 1;     // sum of three squares
  localparam int REM_W = S_W + 1;      // divider remainder
  localparam int D_W   = 2 * FRAC_BITS + 1;  // quotient c*c*2^28 / S
  localparam int Q_W   = FRAC_BITS + 1;      // integer square root of it
  localparam int CNT_W = $clog2(D_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUMV,
    ST_SUMSQ,
    ST_NSTART,
    ST_NWAIT,
    ST_VOUT,
    ST_TRI
  } seq_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_DIV,
    U_SQRT
  } unit_state_t;

  // Number of grid vertices, (n+1)(n+2)/2, for the supported levels.
  function automatic logic [IDX_W-1:0] vertex_count(input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] r;
    case (lvl)
      3'd3:    r = IDX_W'(10);
      3'd4:    r = IDX_W'(15);
      3'd5:    r = IDX_W'(21);
      3'd6:    r = IDX_W'(28);
      default: r = IDX_W'(6);
    endcase
    return r;
  endfunction

endpackage

>>> sv/tst_norm_unit.sv
// Works out the largest q with q*q*S <= c*c*2^28 as isqrt(floor(c*c*2^28 / S)).
// A restoring divider gives one quotient bit a cycle, then a bit-serial
// square root search gives one root bit a cycle.
module tst_norm_unit
  import tst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] mag,
  input  logic [S_W-1:0]   s,
  output logic             done,
  output logic [Q_W-1:0]   q
);

  unit_state_t      ustate;
  logic [REM_W-1:0] rem;
  logic [D_W-1:0]   quo;
  logic [CNT_W-1:0] cnt;
  logic             c0;

  logic [SQ_W-1:0]    c2;
  logic [REM_W-1:0]   sh;
  logic               ge;
  logic [Q_W-1:0]     t;
  logic [2*Q_W-1:0]   tt;

  always_comb begin
    c2 = SQ_W'(mag) * SQ_W'(mag);
    sh = {rem[REM_W-2:0], (cnt == CNT_W'(D_W - 1)) ? c0 : 1'b0};
    ge = sh >= REM_W'(s);
    t  = q | (Q_W'(1) << cnt);
    tt = (2*Q_W)'(t) * (2*Q_W)'(t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ustate)
        U_IDLE: begin
          if (start) begin
            rem    <= REM_W'(c2 >> 1);
            c0     <= c2[0];
            quo    <= '0;
            cnt    <= CNT_W'(D_W - 1);
            ustate <= U_DIV;
          end
        end
        U_DIV: begin
          rem <= ge ? (sh - REM_W'(s)) : sh;
          quo <= {quo[D_W-2:0], ge};
          if (cnt == '0) begin
            cnt    <= CNT_W'(Q_W - 1);
            q      <= '0;
            ustate <= U_SQRT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        U_SQRT: begin
          if (tt <= (2*Q_W)'(quo)) begin
            q <= t;
          end
          if (cnt == '0) begin
            done   <= 1'b1;
            ustate <= U_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: ustate <= U_IDLE;
      endcase
    end
  end

endmodule

>>> sv/triangle_sphere_tessellator.sv
// Geodesic subdivision of one spherical triangle. Each input item holds
// three corners in signed Q1.14; with level n (register, clamped to 2..MAX_LEVEL)
// the block first gives the (n+1)(n+2)/2 grid vertices in row order, each
// the weighted corner sum projected onto the unit sphere and truncated toward
// zero, then the n*n small triangles as triples of global vertex indices taken
// from a running 16-bit counter that start_of_mesh clears. The last result of
// an item carries last_of_run. Each vertex is made in steps: forming the sum
// and its squared length, then for each of the three components a pass through
// the shared normalizing unit (a start, a restoring divider, a square root
// search and taking the root), and loading the vertex into the output register.
// Each triangle enters the output register as soon as the register can take
// it, and a result that waits there holds up the rest of the item. The block
// takes no new item until the last triangle of the current one has entered
// the output register.
module triangle_sphere_tessellator
  import tst_pkg::*;
#(
  parameter int MAX_LEVEL = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [LVL_W-1:0]          cfg_write_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      start_of_mesh,
  input  logic signed [COORD_W-1:0] corner_a_x,
  input  logic signed [COORD_W-1:0] corner_a_y,
  input  logic signed [COORD_W-1:0] corner_a_z,
  input  logic signed [COORD_W-1:0] corner_b_x,
  input  logic signed [COORD_W-1:0] corner_b_y,
  input  logic signed [COORD_W-1:0] corner_b_z,
  input  logic signed [COORD_W-1:0] corner_c_x,
  input  logic signed [COORD_W-1:0] corner_c_y,
  input  logic signed [COORD_W-1:0] corner_c_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      is_triangle,
  output logic signed [COORD_W-1:0] pos_x,
  output logic signed [COORD_W-1:0] pos_y,
  output logic signed [COORD_W-1:0] pos_z,
  output logic [IDX_W-1:0]          tri_first,
  output logic [IDX_W-1:0]          tri_second,
  output logic [IDX_W-1:0]          tri_third,
  output logic                      last_of_run
);

  seq_state_t state, state_next;

  logic [LVL_W-1:0] level;      // configuration register
  logic [LVL_W-1:0] nu;         // clamped level of the current item
  logic [IDX_W-1:0] vertex_base;

  logic signed [COORD_W-1:0] ha [3];
  logic signed [COORD_W-1:0] hb [3];
  logic signed [COORD_W-1:0] hc [3];
  logic signed [V_W-1:0]     vcomp [3];
  logic signed [COORD_W-1:0] res [3];

  logic [LVL_W-1:0] row_pos, col_pos;
  logic [1:0]       comp;
  logic [S_W-1:0]   ssum;
  logic [MAG_W-1:0] sq_mag;
  logic             half;
  logic [IDX_W-1:0] row_start, row_start_nx;

  logic              can_load;
  logic              out_load;
  logic              unit_start, unit_done;
  logic [Q_W-1:0]    unit_q;
  logic [LVL_W-1:0]  k;
  logic signed [V_W-1:0] vsum, vsel;
  logic [MAG_W-1:0]  vsel_mag;
  logic signed [COORD_W-1:0] qs;
  logic [LVL_W-1:0]  clamped;
  logic              row_end, cells_left, last_row;
  logic [IDX_W-1:0]  p0, p1, p2, p3;

  assign in_ready = (state == ST_IDLE);
  assign can_load = !out_valid || out_ready;
  // A new result enters the output register in this cycle.
  assign out_load = can_load && (state == ST_VOUT || state == ST_TRI);

  always_comb begin
    if (level < LVL_W'(2)) begin
      clamped = LVL_W'(2);
    end else if (level > LVL_W'(MAX_LEVEL)) begin
      clamped = LVL_W'(MAX_LEVEL);
    end else begin
      clamped = level;
    end
  end

  // Weighted sum of one component and the magnitude of a stored one.
  always_comb begin
    k    = nu - row_pos - col_pos;
    vsum = V_W'($signed({1'b0, k}) * ha[comp]
              + $signed({1'b0, row_pos}) * hb[comp]
              + $signed({1'b0, col_pos}) * hc[comp]);
    vsel = vcomp[comp];
    vsel_mag = vsel[V_W-1] ? MAG_W'(-vsel) : MAG_W'(vsel);
    qs = vsel[V_W-1] ? -$signed(COORD_W'(unit_q)) : $signed(COORD_W'(unit_q));
  end

  // Triangle walk: rows of cells, two triangles per cell but the last in a row.
  always_comb begin
    row_end    = (col_pos == nu - row_pos);
    cells_left = (col_pos + LVL_W'(1)) < (nu - row_pos);
    last_row   = (row_pos == nu - LVL_W'(1));
    p0 = vertex_base + row_start + IDX_W'(col_pos);
    p1 = vertex_base + row_start_nx + IDX_W'(col_pos);
    p2 = p0 + IDX_W'(1);
    p3 = p1 + IDX_W'(1);
  end

  always_comb begin
    state_next = state;
    unit_start = 1'b0;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SUMV;
      ST_SUMV:   state_next = ST_SUMSQ;
      ST_SUMSQ:  state_next = (comp == 2'd2) ? ST_NSTART : ST_SUMV;
      ST_NSTART: begin
        unit_start = 1'b1;
        state_next = ST_NWAIT;
      end
      ST_NWAIT: begin
        if (unit_done) state_next = (comp == 2'd2) ? ST_VOUT : ST_NSTART;
      end
      ST_VOUT: begin
        if (can_load) state_next = (row_end && row_pos == nu) ? ST_TRI : ST_SUMV;
      end
      ST_TRI: begin
        if (can_load && !half && !cells_left && last_row) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  tst_norm_unit u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .mag   (vsel_mag),
    .s     (ssum),
    .done  (unit_done),
    .q     (unit_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= LVL_W'(2);
      vertex_base <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        level <= cfg_write_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            nu <= clamped;
            if (start_of_mesh) vertex_base <= '0;
            ha[0] <= corner_a_x; ha[1] <= corner_a_y; ha[2] <= corner_a_z;
            hb[0] <= corner_b_x; hb[1] <= corner_b_y; hb[2] <= corner_b_z;
            hc[0] <= corner_c_x; hc[1] <= corner_c_y; hc[2] <= corner_c_z;
            row_pos <= '0;
            col_pos <= '0;
            comp    <= '0;
            ssum    <= '0;
          end
        end
        ST_SUMV: begin
          vcomp[comp] <= vsum;
          sq_mag      <= vsum[V_W-1] ? MAG_W'(-vsum) : MAG_W'(vsum);
        end
        ST_SUMSQ: begin
          ssum <= ssum + S_W'(SQ_W'(sq_mag) * SQ_W'(sq_mag));
          comp <= (comp == 2'd2) ? 2'd0 : comp + 2'd1;
        end
        ST_NWAIT: begin
          if (unit_done) begin
            // A zero sum has no direction; it is given as the origin.
            res[comp] <= (ssum == '0) ? '0 : qs;
            comp      <= (comp == 2'd2) ? 2'd0 : comp + 2'd1;
          end
        end
        ST_VOUT: begin
          if (can_load) begin
            is_triangle <= 1'b0;
            pos_x       <= res[0];
            pos_y       <= res[1];
            pos_z       <= res[2];
            tri_first   <= '0;
            tri_second  <= '0;
            tri_third   <= '0;
            last_of_run <= 1'b0;
            ssum        <= '0;
            if (row_end) begin
              col_pos <= '0;
              if (row_pos == nu) begin
                row_pos      <= '0;
                half         <= 1'b0;
                row_start    <= '0;
                row_start_nx <= IDX_W'(nu) + IDX_W'(1);
              end else begin
                row_pos <= row_pos + LVL_W'(1);
              end
            end else begin
              col_pos <= col_pos + LVL_W'(1);
            end
          end
        end
        ST_TRI: begin
          if (can_load) begin
            is_triangle <= 1'b1;
            pos_x       <= '0;
            pos_y       <= '0;
            pos_z       <= '0;
            tri_first   <= half ? p1 : p0;
            tri_second  <= half ? p3 : p1;
            tri_third   <= p2;
            last_of_run <= !half && !cells_left && last_row;
            if (!half && cells_left) begin
              half <= 1'b1;
            end else if (half) begin
              half    <= 1'b0;
              col_pos <= col_pos + LVL_W'(1);
            end else begin
              // End of a row of cells: step to the next row of vertices.
              col_pos      <= '0;
              row_pos      <= row_pos + LVL_W'(1);
              row_start    <= row_start_nx;
              row_start_nx <= row_start_nx + IDX_W'(nu - row_pos);
              if (last_row) begin
                vertex_base <= vertex_base + vertex_count(nu);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the geodesic tessellator.
//
// An initial block fills a queue of pending triangles, phase by phase. A
// clocked driver offers them on the input channel, and a clocked monitor
// takes results off the output channel. Both sides idle in random bursts.
// Whenever an item is accepted, the driver works out the whole expected run
// for it from its own copy of the level and of the running vertex index:
// the grid vertices first, then the small triangles. The monitor compares
// every result with the oldest expected entry.
//
// The level register is rewritten only once everything in flight has come
// back. It steps through every encodable value. Values below two and above
// six check that the block clamps the level.
module tb_top
  import tst_pkg::*;
();

  localparam int MAX_LVL      = 6;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int HOLD_CYCLES  = 2500;
  localparam int HOLD_AT_ITEM = 150;

  typedef struct {
    logic                      som;
    logic signed [COORD_W-1:0] crn [9];
  } tri_item_t;

  typedef struct {
    logic                      is_tri;
    logic signed [COORD_W-1:0] px, py, pz;
    logic [IDX_W-1:0]          t1, t2, t3;
    logic                      last;
  } mesh_out_t;

  logic clk, rst;
  logic cfg_write_en;
  logic [LVL_W-1:0] cfg_write_data;
  logic in_valid, in_ready, out_valid, out_ready;
  tri_item_t cur_item;
  logic is_triangle, last_of_run;
  logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
  logic [IDX_W-1:0] tri_first, tri_second, tri_third;

  tri_item_t pending_tris[$];
  mesh_out_t expected_mesh[$];

  // Bench copies of the level register and of the running vertex index.
  logic [LVL_W-1:0] level_now;
  logic [IDX_W-1:0] next_vertex;

  int  accepted_tris, checked_results, mismatches, cycles;
  int  in_gap, out_gap, hold_left;
  bit  quiet, hold_done;

  triangle_sphere_tessellator #(.MAX_LEVEL(MAX_LVL)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_of_mesh(cur_item.som),
    .corner_a_x(cur_item.crn[0]), .corner_a_y(cur_item.crn[1]),
    .corner_a_z(cur_item.crn[2]),
    .corner_b_x(cur_item.crn[3]), .corner_b_y(cur_item.crn[4]),
    .corner_b_z(cur_item.crn[5]),
    .corner_c_x(cur_item.crn[6]), .corner_c_y(cur_item.crn[7]),
    .corner_c_z(cur_item.crn[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_triangle(is_triangle), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .tri_first(tri_first), .tri_second(tri_second), .tri_third(tri_third),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_expected(input mesh_out_t e);
    expected_mesh.insert(expected_mesh.size(), e);
  endfunction

  function automatic void queue_tri(input tri_item_t t);
    pending_tris.insert(pending_tris.size(), t);
  endfunction

  // This projects one component onto the sphere. The result is the largest q
  // for which q*q*S <= c*c*2^28. It is found bit by bit in 128-bit arithmetic,
  // so nothing overflows even with full-scale corners at level six.
  function automatic logic [COORD_W-1:0] project_comp(longint c, logic [127:0] s);
    logic [127:0] mag, rhs, q, t;
    if (s == 0) return '0;
    mag = (c < 0) ? 128'(-c) : 128'(c);
    rhs = (mag * mag) << (2 * FRAC_BITS);
    q = '0;
    for (int b = FRAC_BITS; b >= 0; b--) begin
      t = q | (128'(1) << b);
      if (t * t * s <= rhs) q = t;
    end
    return (c < 0) ? COORD_W'(-q) : COORD_W'(q);
  endfunction

  // This gives the position of grid vertex (i, j) within one triangle's vertex list.
  function automatic int grid_slot(int nu, int i, int j);
    return i * (nu + 1) - (i * (i - 1)) / 2 + j;
  endfunction

  function automatic mesh_out_t tri_entry(int a, int b, int c);
    mesh_out_t e;
    e = '{is_tri: 1'b1, px: '0, py: '0, pz: '0, last: 1'b0,
          t1: next_vertex + IDX_W'(a), t2: next_vertex + IDX_W'(b),
          t3: next_vertex + IDX_W'(c)};
    return e;
  endfunction

  // This works out the whole run that one accepted triangle causes, and then
  // moves the running vertex index on.
  task automatic tessellate(input tri_item_t it);
    int nu, k;
    longint v[3];
    logic [127:0] s;
    mesh_out_t e;
    nu = (level_now < 2) ? 2 : ((level_now > MAX_LVL) ? MAX_LVL : int'(level_now));
    if (it.som) next_vertex = '0;
    for (int i = 0; i <= nu; i++)
      for (int j = 0; j <= nu - i; j++) begin
        k = nu - i - j;
        s = '0;
        for (int d = 0; d < 3; d++) begin
          v[d] = k * longint'(it.crn[d]) + i * longint'(it.crn[3+d])
               + j * longint'(it.crn[6+d]);
          s += 128'(v[d] * v[d]);
        end
        e = '{is_tri: 1'b0, px: project_comp(v[0], s), py: project_comp(v[1], s),
              pz: project_comp(v[2], s), t1: '0, t2: '0, t3: '0, last: 1'b0};
        add_expected(e);
      end
    // Each cell gives its upward triangle and then, if it has one, the
    // downward triangle beside it.
    for (int i = 0; i < nu; i++)
      for (int j = 0; j < nu - i; j++) begin
        add_expected(tri_entry(grid_slot(nu, i, j), grid_slot(nu, i + 1, j),
                               grid_slot(nu, i, j + 1)));
        if (j + 1 < nu - i)
          add_expected(tri_entry(grid_slot(nu, i + 1, j),
                                 grid_slot(nu, i + 1, j + 1),
                                 grid_slot(nu, i, j + 1)));
      end
    expected_mesh[$].last = 1'b1;
    next_vertex += IDX_W'((nu + 1) * (nu + 2) / 2);
  endtask

  // Driver. A held item is never dropped. A new item follows an accepted one
  // at once, unless an idle burst has been drawn.
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
      next_vertex = '0;
    end else begin
      if (in_valid && in_ready) begin
        tessellate(cur_item);
        accepted_tris++;
      end
      if (!(in_valid && !in_ready)) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_tris.size() > 0) begin
          cur_item <= pending_tris.pop_front();
          nv = 1'b1;
          if (!quiet && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 13);
        end
        in_valid <= nv;
      end
    end
  end

  // This is the long output hold-off. It runs once, so that the result register
  // fills up and the input side stalls while the driver keeps offering items.
  always @(posedge clk) begin
    if (rst) begin
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (!hold_done && accepted_tris >= HOLD_AT_ITEM) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
  end

  // Monitor, with random back-pressure.
  always @(posedge clk) begin
    mesh_out_t e;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_mesh.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: tri=%0b pos=%0d,%0d,%0d",
                                          is_triangle, pos_x, pos_y, pos_z);
        end else begin
          e = expected_mesh.pop_front();
          checked_results++;
          if (is_triangle !== e.is_tri || pos_x !== e.px || pos_y !== e.py ||
              pos_z !== e.pz || tri_first !== e.t1 || tri_second !== e.t2 ||
              tri_third !== e.t3 || last_of_run !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at result %0d:", checked_results);
              $display("  expected tri=%0b pos=%0d,%0d,%0d idx=%0d,%0d,%0d last=%0b",
                       e.is_tri, e.px, e.py, e.pz, e.t1, e.t2, e.t3, e.last);
              $display("  actual   tri=%0b pos=%0d,%0d,%0d idx=%0d,%0d,%0d last=%0b",
                       is_triangle, pos_x, pos_y, pos_z, tri_first, tri_second,
                       tri_third, last_of_run);
            end
          end
        end
      end
      if (out_gap > 0) out_gap--;
      else if (!quiet && $urandom_range(0, 6) == 0) out_gap = $urandom_range(1, 13);
      out_ready <= (out_gap == 0) && (hold_left == 0);
    end
  end

  // This is the watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic tri_item_t make_tri(logic som, int ax, int ay, int az,
                                         int bx, int by, int bz,
                                         int cx, int cy, int cz);
    tri_item_t t;
    t.som = som;
    t.crn = '{COORD_W'(ax), COORD_W'(ay), COORD_W'(az), COORD_W'(bx), COORD_W'(by),
              COORD_W'(bz), COORD_W'(cx), COORD_W'(cy), COORD_W'(cz)};
    return t;
  endfunction

  // Mostly well-formed corners in the unit range. Some carry any 16-bit pattern,
  // and some have B opposite A so that a grid sum can cancel to zero.
  function automatic tri_item_t random_tri();
    tri_item_t t;
    int kind;
    kind = $urandom_range(0, 19);
    t.som = ($urandom_range(0, 7) == 0);
    for (int n = 0; n < 9; n++)
      t.crn[n] = (kind < 3) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 32768) - 16384);
    if (kind == 3)
      for (int d = 0; d < 3; d++) t.crn[3+d] = -t.crn[d];
    return t;
  endfunction

  task automatic drain();
    while (pending_tris.size() > 0 || in_valid || expected_mesh.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_level(input logic [LVL_W-1:0] lvl);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= lvl;
    level_now = lvl;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic random_phase(input logic [LVL_W-1:0] lvl, input int n);
    set_level(lvl);
    repeat (n) queue_tri(random_tri());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    level_now = 3'd2;
    quiet = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed triangles, at the level left by reset. They cover the axis octant,
    // full-scale and most negative corners, all-zero corners, and opposite
    // corners that cancel in the middle of an edge.
    queue_tri(make_tri(1, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    queue_tri(make_tri(0, -16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    queue_tri(make_tri(0, 32767, 32767, 32767, -32768, -32768, -32768,
                       32767, -32768, 32767));
    queue_tri(make_tri(0, -32768, -32768, -32768, -32768, -32768, -32768,
                       -32768, -32768, -32768));
    queue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_tri(make_tri(0, 16384, 0, 0, -16384, 0, 0, 0, 16384, 0));
    queue_tri(make_tri(1, 0, 0, 16384, 0, 0, -16384, 0, 0, -16384));
    queue_tri(make_tri(0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    queue_tri(make_tri(0, 9459, 9459, 9459, -9459, 9459, -9459,
                       9459, -9459, -9459));
    queue_tri(make_tri(0, 32767, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_tri(make_tri(1, 100, -200, 300, 16383, -16383, 1, -1, 2, -3));
    drain();

    // Each phase uses one level. The set includes both clamped values below two,
    // the clamped value above six, and every level that the block supports.
    random_phase(3'd0, 10);
    random_phase(3'd7, 8);
    random_phase(3'd3, 10);
    random_phase(3'd4, 8);
    random_phase(3'd5, 8);
    random_phase(3'd6, 8);
    random_phase(3'd1, 10);
    random_phase(3'd2, 260);

    // The tail of the run has no idling on either side.
    quiet = 1'b1;
    random_phase(3'd2, 30);

    $display("checked %0d results from %0d triangles at levels 0 to 7,", checked_results,
             accepted_tris);
    $display("including a long output stall; %0d mismatches", mismatches);
    if (mismatches == 0 && expected_mesh.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
